>>> src/rht_pkg.sv
`default_nettype none
package rht_pkg;

	localparam logic [31:0] MIX_C1      = 32'h7FEB352D;
	localparam logic [31:0] MIX_C2      = 32'h846CA68B;
	localparam logic [31:0] HASH_GOLDEN = 32'h9E3779B9;
	localparam logic [15:0] REFS_MAX    = 16'hFFFF;

	localparam logic [1:0] REQ_LOOKUP  = 2'd0;
	localparam logic [1:0] REQ_ACQUIRE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_TOMB  = 2'd1;
	localparam logic [1:0] TAG_LIVE  = 2'd2;

	typedef enum logic [2:0] {
		STATUS_HIT      = 3'd0,
		STATUS_INSERTED = 3'd1,
		STATUS_MISS     = 3'd2,
		STATUS_REMOVED  = 3'd3,
		STATUS_HELD     = 3'd4,
		STATUS_FULL     = 3'd5,
		STATUS_ERROR    = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_POST,
		S_MOD,
		S_RD,
		S_CHK,
		S_ACT,
		S_MOVE
	} state_t;

	typedef struct packed {
		logic [31:0] sb_key;
		logic [31:0] node_key;
		logic [15:0] refs;
	} entry_t;

endpackage
`default_nettype wire

>>> src/rht_ifs.sv
`default_nettype none
interface rht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] sb_id;
	logic [31:0] node_id;

	modport source (output valid, output req_type, output sb_id, output node_id, input ready);
	modport sink (input valid, input req_type, input sb_id, input node_id, output ready);
endinterface

interface rht_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] use_count;

	modport source (output valid, output status, output use_count, input ready);
	modport sink (input valid, input status, input use_count, output ready);
endinterface
`default_nettype wire

>>> src/refcounted_hash_table.sv
`default_nettype none
// Channel  Dir  Payload                      Transfer
// req      in   req_type, sb_id, node_id     valid && ready
// rsp      out  status, use_count            valid && ready
//
// Hash: four multiplies on one 32x32 multiplier with a register after each;
//   plus remainder by reciprocal multiplication when SLOTS is not a power of two.
// Probe: a registered read of the slot arrays, then a check, per slot visited; then an
//   update step, and a move step when a lookup moves its entry into an earlier tombstone.
// Reset: the tag array is cleared one slot a cycle, req not ready meanwhile.
// Stalls: a new request is taken while the last result waits; its final step holds until
//   the result register frees.
module refcounted_hash_table
	import rht_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	rht_req_if.sink     req,
	rht_rsp_if.source   rsp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [11:0] FOLD_P = 12'((32'd1 << 16) % SLOTS);
	localparam int QUOT_SH = 29 + IDX_W;
	localparam logic [30:0] RECIP_M = 31'(((64'd1 << QUOT_SH) / 64'(SLOTS)) + 64'd1);

	state_t state_q, state_d;

	logic [1:0]       tag_mem [SLOTS];
	entry_t           ent_mem [SLOTS];
	logic [1:0]       tag_rd_q;
	entry_t           ent_rd_q;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] n_q;
	logic [1:0]       step_q;
	logic [1:0]       mod_step_q;
	logic             found_q, have_tomb_q, have_free_q;
	logic             rsp_valid_q;

	logic [1:0]       req_q;
	logic [31:0]      sb_q, node_q;
	logic [31:0]      op_q, prod_q, mix_sb_q, hash_q;
	logic [28:0]      fold_q, quot_q;
	logic [IDX_W-1:0] hit_q, tomb_q, free_q;
	logic [15:0]      hit_refs_q;
	status_t          status_q;
	logic [15:0]      count_q;

	logic [31:0]      mconst, prod_d, mixv, hash_d;
	logic [28:0]      fold_d, quot_d, rem_d;
	logic [59:0]      quot_prod;
	logic [IDX_W-1:0] idx_inc;
	logic             match, chk_done, act_go, need_move, bad_req, sat;
	logic [15:0]      refs_inc;

	logic             tag_we, ent_we, res_load;
	logic [IDX_W-1:0] tag_wa, ent_wa;
	logic [1:0]       tag_wd;
	entry_t           ent_wd;
	status_t          res_status;
	logic [15:0]      res_count;

	always_comb begin
		mconst   = step_q[0] ? MIX_C2 : MIX_C1;
		prod_d   = op_q * mconst;
		mixv     = prod_q ^ (prod_q >> 16);
		hash_d   = mix_sb_q ^ (mixv + HASH_GOLDEN + (sb_q << 6) + (sb_q >> 2));
		fold_d   = 29'(hash_q[31:16]) * 29'(FOLD_P) + 29'(hash_q[15:0]);
		quot_prod = 60'(fold_q) * 60'(RECIP_M);
		quot_d   = 29'(quot_prod >> QUOT_SH);
		rem_d    = fold_q - quot_q * 29'(SLOTS);
		idx_inc  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
		match    = (tag_rd_q == TAG_LIVE) && (ent_rd_q.sb_key == sb_q)
			&& (ent_rd_q.node_key == node_q);
		chk_done = (tag_rd_q == TAG_EMPTY) || match || (n_q == LAST_IDX);
		act_go   = !rsp_valid_q || rsp.ready;
		bad_req  = (req_q != REQ_LOOKUP) && (req_q != REQ_ACQUIRE) && (req_q != REQ_RELEASE);
		need_move = (req_q == REQ_LOOKUP) && found_q && have_tomb_q;
		sat      = (hit_refs_q == REFS_MAX);
		refs_inc = sat ? hit_refs_q : hit_refs_q + 16'd1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (idx_q == LAST_IDX) state_d = S_IDLE;
			S_IDLE: begin
				if (req.valid) begin
					if ((req.req_type != REQ_LOOKUP) && (req.req_type != REQ_ACQUIRE)
						&& (req.req_type != REQ_RELEASE)) begin
						state_d = S_ACT;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: state_d = S_POST;
			S_POST: begin
				if (step_q == 2'd3) begin
					state_d = IS_POW2 ? S_RD : S_MOD;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MOD: if (mod_step_q == 2'd2) state_d = S_RD;
			S_RD: state_d = S_CHK;
			S_CHK: state_d = chk_done ? S_ACT : S_RD;
			S_ACT: if (act_go) state_d = need_move ? S_MOVE : S_IDLE;
			S_MOVE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = (state_q == S_IDLE);
		tag_we     = 1'b0;
		tag_wa     = idx_q;
		tag_wd     = TAG_EMPTY;
		ent_we     = 1'b0;
		ent_wa     = hit_q;
		ent_wd     = '{sb_key: sb_q, node_key: node_q, refs: refs_inc};
		res_load   = 1'b0;
		res_status = STATUS_ERROR;
		res_count  = '0;
		unique case (state_q)
			S_CLEAR: tag_we = 1'b1;
			S_ACT: begin
				res_load = act_go;
				if (!bad_req) begin
					unique case (req_q)
						REQ_LOOKUP: begin
							if (found_q) begin
								res_status = sat ? STATUS_ERROR : STATUS_HIT;
								res_count  = refs_inc;
								ent_we     = act_go;
								if (have_tomb_q) begin
									ent_wa = tomb_q;
									tag_we = act_go;
									tag_wa = tomb_q;
									tag_wd = TAG_LIVE;
								end
							end else begin
								res_status = STATUS_MISS;
							end
						end
						REQ_ACQUIRE: begin
							if (found_q) begin
								res_status = sat ? STATUS_ERROR : STATUS_HIT;
								res_count  = refs_inc;
								ent_we     = act_go;
							end else if (have_free_q) begin
								res_status = STATUS_INSERTED;
								res_count  = 16'd1;
								ent_we     = act_go;
								ent_wa     = free_q;
								ent_wd.refs = 16'd1;
								tag_we     = act_go;
								tag_wa     = free_q;
								tag_wd     = TAG_LIVE;
							end else begin
								res_status = STATUS_FULL;
							end
						end
						REQ_RELEASE: begin
							if (found_q) begin
								if (hit_refs_q <= 16'd1) begin
									res_status = STATUS_REMOVED;
									tag_we     = act_go;
									tag_wa     = hit_q;
									tag_wd     = TAG_TOMB;
								end else begin
									res_status  = STATUS_HELD;
									res_count   = hit_refs_q - 16'd1;
									ent_we      = act_go;
									ent_wd.refs = hit_refs_q - 16'd1;
								end
							end
						end
						default: res_status = STATUS_ERROR;
					endcase
				end
			end
			S_MOVE: begin
				tag_we = 1'b1;
				tag_wa = hit_q;
				tag_wd = TAG_TOMB;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= tag_wd;
		tag_rd_q <= tag_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		ent_rd_q <= ent_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			n_q         <= '0;
			step_q      <= '0;
			mod_step_q  <= '0;
			found_q     <= 1'b0;
			have_tomb_q <= 1'b0;
			have_free_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: idx_q <= idx_inc;
				S_IDLE: begin
					n_q         <= '0;
					step_q      <= '0;
					mod_step_q  <= '0;
					found_q     <= 1'b0;
					have_tomb_q <= 1'b0;
					have_free_q <= 1'b0;
				end
				S_POST: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) idx_q <= hash_d[IDX_W-1:0];
				end
				S_MOD: begin
					mod_step_q <= mod_step_q + 2'd1;
					if (mod_step_q == 2'd2) idx_q <= rem_d[IDX_W-1:0];
				end
				S_CHK: begin
					if (tag_rd_q == TAG_EMPTY) begin
						have_free_q <= 1'b1;
					end else if (tag_rd_q == TAG_TOMB) begin
						have_tomb_q <= 1'b1;
						have_free_q <= 1'b1;
					end else if (match) begin
						found_q <= 1'b1;
					end
					if (!chk_done) begin
						n_q   <= n_q + 1'b1;
						idx_q <= idx_inc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q  <= req.req_type;
				sb_q   <= req.sb_id;
				node_q <= req.node_id;
				op_q   <= req.sb_id ^ (req.sb_id >> 16);
			end
			S_MUL: prod_q <= prod_d;
			S_POST: begin
				unique case (step_q)
					2'd1: begin
						mix_sb_q <= mixv;
						op_q     <= node_q ^ (node_q >> 16);
					end
					2'd3: hash_q <= hash_d;
					default: op_q <= prod_q ^ (prod_q >> 15);
				endcase
			end
			S_MOD: begin
				if (mod_step_q == 2'd0) fold_q <= fold_d;
				if (mod_step_q == 2'd1) quot_q <= quot_d;
			end
			S_CHK: begin
				if ((tag_rd_q == TAG_EMPTY) && !have_free_q) free_q <= idx_q;
				if (tag_rd_q == TAG_TOMB) begin
					if (!have_tomb_q) tomb_q <= idx_q;
					if (!have_free_q) free_q <= idx_q;
				end
				if (match) begin
					hit_q      <= idx_q;
					hit_refs_q <= ent_rd_q.refs;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			status_q <= res_status;
			count_q  <= res_count;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.use_count = count_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");

	a_tomb_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		have_tomb_q |-> have_free_q)
		else $error("tombstone seen but no free slot recorded");

	a_hit_not_tomb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACT) && found_q && have_tomb_q |-> hit_q != tomb_q)
		else $error("hit slot equals first tombstone");

	a_move_after_act: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> $past(state_q) == S_ACT && $past(need_move))
		else $error("entry move without a lookup hit");
`endif

endmodule
`default_nettype wire
